// File: design/assert_macros.svh
// Assertion macros shared by the blitter design files.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: design/cpb_pkg.sv
// Types and codes of the clipped palette blitter.
// No dependencies; used by cpb_walk and the top level.
package cpb_pkg;

   localparam int COORD_BITS = 12;
   localparam int ADDR_BITS  = 22;
   localparam int COLOR_BITS = 32;

   // Request command codes.
   localparam logic [2:0] CMD_GLYPH   = 3'd0;
   localparam logic [2:0] CMD_PICTURE = 3'd1;
   localparam logic [2:0] CMD_FILL    = 3'd2;
   localparam logic [2:0] CMD_PALETTE = 3'd3;
   localparam logic [2:0] CMD_STEP    = 3'd4;

   // Draw modes.
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_GLYPH   = 2'd1;
   localparam logic [1:0] MODE_PICTURE = 2'd2;
   localparam logic [1:0] MODE_FILL    = 2'd3;

   // Color keys.
   localparam logic [7:0] KEY_GLYPH   = 8'h00;
   localparam logic [7:0] KEY_PICTURE = 8'hff;

   // Configuration register indexes.
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   typedef struct packed {
      logic [2:0]                   cmd;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic [COORD_BITS-1:0]        area_width;
      logic [COORD_BITS-1:0]        area_height;
      logic [7:0]                   source_pixel;
      logic [7:0]                   red;
      logic [7:0]                   green;
      logic [7:0]                   blue;
      logic [COLOR_BITS-1:0]        palette_value;
   } req_type;

   typedef struct packed {
      logic                  write_enable;
      logic [ADDR_BITS-1:0]  pixel_address;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } rsp_type;

   // One step position as the walker hands it to the pipeline.
   typedef struct packed {
      logic                  valid;
      logic                  on_screen;
      logic                  opaque;
      logic                  is_fill;
      logic                  last;
      logic [COORD_BITS-1:0] sx;
      logic [COORD_BITS-1:0] sy;
      logic [COLOR_BITS-1:0] fill_color;
   } step_type;

endpackage

// File: design/cpb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the blitter's palette.
module cpb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/cpb_walk.sv
// Draw state of the blitter: begins commands, walks positions in raster order, clips.
// Depends on cpb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpb_walk #(
   parameter int GLYPH_SIZE = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  cpb_pkg::req_type              item,
   input  logic [cpb_pkg::COORD_BITS-1:0] screen_width,
   input  logic [cpb_pkg::COORD_BITS-1:0] screen_height,
   output cpb_pkg::step_type             step
);
   import cpb_pkg::*;

   localparam int SW = COORD_BITS + 2;

   logic [1:0]                   mode_ff, mode_in;
   logic signed [COORD_BITS-1:0] origin_x_ff, origin_x_in;
   logic signed [COORD_BITS-1:0] origin_y_ff, origin_y_in;
   logic [COORD_BITS-1:0]        extent_w_ff, extent_w_in;
   logic [COORD_BITS-1:0]        extent_h_ff, extent_h_in;
   logic [COORD_BITS-1:0]        column_ff, column_in;
   logic [COORD_BITS-1:0]        row_ff, row_in;
   logic [COLOR_BITS-1:0]        fill_color_ff, fill_color_in;

   logic signed [SW-1:0] sx;
   logic signed [SW-1:0] sy;
   logic [COORD_BITS:0]  column_next;
   logic [COORD_BITS:0]  row_next;
   logic                 row_end;
   logic                 is_begin;
   logic                 is_step;
   logic [1:0]           begin_mode;

   always_comb begin
      sx = SW'(origin_x_ff) + SW'({2'b00, column_ff});
      sy = SW'(origin_y_ff) + SW'({2'b00, row_ff});
      column_next = {1'b0, column_ff} + (COORD_BITS+1)'(1);
      row_next = {1'b0, row_ff} + (COORD_BITS+1)'(1);
      row_end = column_next >= {1'b0, extent_w_ff};

      step.valid = item.cmd == CMD_STEP && mode_ff != MODE_IDLE;
      step.on_screen = !sx[SW-1] && !sy[SW-1]
         && sx[SW-2:0] < (SW-1)'(screen_width)
         && sy[SW-2:0] < (SW-1)'(screen_height);
      step.is_fill = mode_ff == MODE_FILL;
      step.opaque = (mode_ff == MODE_FILL)
         || (item.source_pixel != ((mode_ff == MODE_GLYPH) ? KEY_GLYPH : KEY_PICTURE));
      step.last = row_end && row_next >= {1'b0, extent_h_ff};
      step.sx = sx[COORD_BITS-1:0];
      step.sy = sy[COORD_BITS-1:0];
      step.fill_color = fill_color_ff;
   end

   always_comb begin
      is_begin = item.cmd == CMD_GLYPH || item.cmd == CMD_PICTURE || item.cmd == CMD_FILL;
      is_step = step.valid;
      begin_mode = item.cmd[1:0] + 2'd1;

      mode_in = mode_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      extent_w_in = extent_w_ff;
      extent_h_in = extent_h_ff;
      column_in = column_ff;
      row_in = row_ff;
      fill_color_in = fill_color_ff;

      if (accept && is_begin) begin
         origin_x_in = item.pos_x;
         origin_y_in = item.pos_y;
         if (item.cmd == CMD_GLYPH) begin
            extent_w_in = COORD_BITS'(GLYPH_SIZE);
            extent_h_in = COORD_BITS'(GLYPH_SIZE);
         end else begin
            extent_w_in = item.area_width;
            extent_h_in = item.area_height;
         end
         if (item.cmd == CMD_FILL) begin
            fill_color_in = {8'hff, item.red, item.green, item.blue};
         end
         column_in = '0;
         row_in = '0;
         mode_in = (extent_w_in == '0 || extent_h_in == '0) ? MODE_IDLE : begin_mode;
      end else if (accept && is_step) begin
         if (step.last) begin
            mode_in = MODE_IDLE;
            column_in = '0;
            row_in = '0;
         end else if (row_end) begin
            column_in = '0;
            row_in = row_next[COORD_BITS-1:0];
         end else begin
            column_in = column_next[COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         extent_w_ff <= '0;
         extent_h_ff <= '0;
         column_ff <= '0;
         row_ff <= '0;
         fill_color_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         extent_w_ff <= extent_w_in;
         extent_h_ff <= extent_h_in;
         column_ff <= column_in;
         row_ff <= row_in;
         fill_color_ff <= fill_color_in;
      end
   end

   // An active draw always has a nonempty area to walk.
   `ASSERT_SAME(a_active_nonempty, clock, reset, mode_ff != MODE_IDLE,
      extent_w_ff != '0 && extent_h_ff != '0)
   // Taking the final position of a draw returns the walker to idle.
   `ASSERT_NEXT(a_last_goes_idle, clock, reset, accept && step.valid && step.last,
      mode_ff == MODE_IDLE && column_ff == '0 && row_ff == '0)

endmodule

// File: design/clipped_palette_blitter_top.sv
// Top level of the clipped palette blitter: request pipeline, palette RAM, config registers.
// Depends on cpb_pkg, cpb_walk, cpb_ram and assert_macros.svh.
//
// The blitter takes one request per clock while req_stall is low and returns
// the result of a step through two registered stages: stage one registers the
// walker's clipped position and launches the palette read, stage two registers the
// framebuffer index (row times screen width plus column) and the chosen color.
// Begin, palette write and idle step requests produce no result. A stall on the
// result side holds the whole two-stage pipeline and is passed straight back as
// req_stall, so sustained throughput is one request per cycle whenever results
// are taken. The palette is a 256-entry RAM with one write and one registered read
// port; a palette write takes effect for the very next step request. Screen width
// and height may only be changed while no draw is in flight.
`include "assert_macros.svh"

module clipped_palette_blitter_top #(
   parameter int PALETTE_DEPTH = 256,
   parameter int GLYPH_SIZE    = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cpb_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cpb_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_enable,
   input  logic                           csr_index,
   input  logic [cpb_pkg::COORD_BITS-1:0] csr_data
);
   import cpb_pkg::*;

   localparam int IDX_W = $clog2(PALETTE_DEPTH);

   // Slot of an 8-bit palette index, wrapped to the palette depth. The quotient
   // is below sixteen, so four restoring subtract steps are enough.
   function automatic logic [IDX_W-1:0] pal_slot(input logic [7:0] pix);
      logic [11:0] rem;
      rem = {4'b0000, pix};
      for (int i = 3; i >= 0; i--) begin
         if (rem >= (12'(PALETTE_DEPTH) << i)) begin
            rem = rem - (12'(PALETTE_DEPTH) << i);
         end
      end
      return rem[IDX_W-1:0];
   endfunction

   logic [COORD_BITS-1:0] screen_width_ff;
   logic [COORD_BITS-1:0] screen_height_ff;

   logic       advance;
   logic       accept;
   step_type   step;
   logic [IDX_W-1:0] slot;

   logic       s1_valid_ff, s1_valid_in;
   step_type   s1_ff;
   logic [COLOR_BITS-1:0] pal_color;

   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       enable;
   logic [2*COORD_BITS-1:0] product;

   // The pipeline moves whenever the output register is empty or being taken.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept = req_valid && advance;
   assign slot = pal_slot(req_data.source_pixel);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= COORD_BITS'(320);
         screen_height_ff <= COORD_BITS'(200);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_SCREEN_WIDTH) begin
            screen_width_ff <= csr_data;
         end else begin
            screen_height_ff <= csr_data;
         end
      end
   end

   cpb_walk #(
      .GLYPH_SIZE(GLYPH_SIZE)
   ) u_walk (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .item          (req_data),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .step          (step)
   );

   // Palette writes land at the accept edge; step reads are registered in step
   // with the first pipeline stage, so both hold together under a stall.
   cpb_ram #(
      .WIDTH(COLOR_BITS),
      .DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (accept && req_data.cmd == CMD_PALETTE),
      .wr_addr (slot),
      .wr_data (req_data.palette_value),
      .rd_en   (accept),
      .rd_addr (slot),
      .rd_data (pal_color)
   );

   // Stage one: the clipped position of a step taken while a draw is active.
   assign s1_valid_in = accept && step.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= step;
      end
   end

   // Stage two: framebuffer index and color. A disabled write carries zeros.
   always_comb begin
      enable = s1_ff.on_screen && s1_ff.opaque;
      product = (2*COORD_BITS)'(s1_ff.sy) * (2*COORD_BITS)'(screen_width_ff);
      rsp_in.write_enable = enable;
      rsp_in.pixel_address = enable
         ? ADDR_BITS'(product + (2*COORD_BITS)'(s1_ff.sx)) : '0;
      rsp_in.color = enable ? (s1_ff.is_fill ? s1_ff.fill_color : pal_color) : '0;
      rsp_in.last = s1_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // A result whose write is disabled never carries an address or a color.
   `ASSERT_SAME(a_disabled_is_zero, clock, reset, rsp_valid_ff && !rsp_ff.write_enable,
      rsp_ff.pixel_address == '0 && rsp_ff.color == '0)
   // A step held in stage one reaches the output register when the pipeline moves.
   `ASSERT_NEXT(a_stage_moves, clock, reset, s1_valid_ff && advance, rsp_valid_ff)

endmodule
